// ----- rtl/rgbsps_pkg.sv -----
// Package for the RGB status pattern sequencer: pattern codes, colours,
// register indexes, timing defaults and the transaction and config structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rgbsps_pkg;

	localparam int TIMER_W = 16;
	localparam int CFG_W   = 16;
	localparam int IDX_W   = 3;

	localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

	typedef enum logic [2:0] {
		PAT_OFF     = 3'd0,
		PAT_SOLID   = 3'd1,
		PAT_SLOW    = 3'd2,
		PAT_FAST    = 3'd3,
		PAT_DOUBLE  = 3'd4,
		PAT_SUCCESS = 3'd5,
		PAT_ERROR   = 3'd6
	} pattern_t;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_SLOW_HALF    = 3'd0;
	localparam logic [IDX_W-1:0] REG_FAST_HALF    = 3'd1;
	localparam logic [IDX_W-1:0] REG_FLASH_HALF   = 3'd2;
	localparam logic [IDX_W-1:0] REG_DOUBLE_GAP   = 3'd3;
	localparam logic [IDX_W-1:0] REG_SUCCESS_HOLD = 3'd4;
	localparam logic [IDX_W-1:0] REG_ERROR_ON     = 3'd5;
	localparam logic [IDX_W-1:0] REG_ERROR_TOTAL  = 3'd6;

	localparam logic [CFG_W-1:0] RST_SLOW_HALF    = 16'd500;
	localparam logic [CFG_W-1:0] RST_FAST_HALF    = 16'd150;
	localparam logic [CFG_W-1:0] RST_FLASH_HALF   = 16'd100;
	localparam logic [CFG_W-1:0] RST_DOUBLE_GAP   = 16'd600;
	localparam logic [CFG_W-1:0] RST_SUCCESS_HOLD = 16'd1000;
	localparam logic [CFG_W-1:0] RST_ERROR_ON     = 16'd500;
	localparam logic [CFG_W-1:0] RST_ERROR_TOTAL  = 16'd2000;

	localparam logic [7:0] LEVEL_DIM    = 8'd20;
	localparam logic [7:0] LEVEL_CYAN   = 8'd15;
	localparam logic [7:0] LEVEL_BRIGHT = 8'd30;

	localparam logic [2:0] DOUBLE_TOGGLES  = 3'd4;
	localparam logic [2:0] SUCCESS_TOGGLES = 3'd6;

	localparam logic [23:0] COLOR_BLACK     = 24'd0;
	localparam logic [23:0] COLOR_DIM_GREEN = {8'd0, LEVEL_DIM, 8'd0};
	localparam logic [23:0] COLOR_DIM_BLUE  = {8'd0, 8'd0, LEVEL_DIM};
	localparam logic [23:0] COLOR_CYAN      = {8'd0, LEVEL_CYAN, LEVEL_CYAN};
	localparam logic [23:0] COLOR_GREEN     = {8'd0, LEVEL_BRIGHT, 8'd0};
	localparam logic [23:0] COLOR_RED       = {LEVEL_BRIGHT, 8'd0, 8'd0};

	typedef struct packed {
		logic       mode;
		logic [2:0] pattern;
	} in_item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [2:0] active_pattern;
		logic       lit;
	} out_item_t;

	typedef struct packed {
		logic [CFG_W-1:0] slow_half_period;
		logic [CFG_W-1:0] fast_half_period;
		logic [CFG_W-1:0] flash_half_period;
		logic [CFG_W-1:0] double_gap;
		logic [CFG_W-1:0] success_hold;
		logic [CFG_W-1:0] error_on_time;
		logic [CFG_W-1:0] error_total_time;
	} cfg_t;

endpackage

`default_nettype wire

// ----- rtl/rgbsps_cfg.sv -----
// Configuration register bank for the pattern sequencer timings.
// Depends on rgbsps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rgbsps_cfg (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_we,
	input  wire  [rgbsps_pkg::IDX_W-1:0]  cfg_index,
	input  wire  [rgbsps_pkg::CFG_W-1:0]  cfg_wdata,
	output rgbsps_pkg::cfg_t              cfg
);
	import rgbsps_pkg::*;

	cfg_t regs_q;

	assign cfg = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.slow_half_period  <= RST_SLOW_HALF;
			regs_q.fast_half_period  <= RST_FAST_HALF;
			regs_q.flash_half_period <= RST_FLASH_HALF;
			regs_q.double_gap        <= RST_DOUBLE_GAP;
			regs_q.success_hold      <= RST_SUCCESS_HOLD;
			regs_q.error_on_time     <= RST_ERROR_ON;
			regs_q.error_total_time  <= RST_ERROR_TOTAL;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SLOW_HALF:    regs_q.slow_half_period  <= cfg_wdata;
				REG_FAST_HALF:    regs_q.fast_half_period  <= cfg_wdata;
				REG_FLASH_HALF:   regs_q.flash_half_period <= cfg_wdata;
				REG_DOUBLE_GAP:   regs_q.double_gap        <= cfg_wdata;
				REG_SUCCESS_HOLD: regs_q.success_hold      <= cfg_wdata;
				REG_ERROR_ON:     regs_q.error_on_time     <= cfg_wdata;
				REG_ERROR_TOTAL:  regs_q.error_total_time  <= cfg_wdata;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/rgbsps_core.sv -----
// Input register and pattern state machine: one transaction updates the
// pattern, colour, elapsed counters and flash count. Depends on rgbsps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rgbsps_core (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire rgbsps_pkg::cfg_t cfg,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  wire rgbsps_pkg::in_item_t in_data,
	output logic                  res_valid,
	input  wire                   res_ready,
	output rgbsps_pkg::out_item_t res_data
);
	import rgbsps_pkg::*;

	function automatic logic [TIMER_W-1:0] sat_inc(input logic [TIMER_W-1:0] v);
		return (v == TIMER_MAX) ? v : v + TIMER_W'(1);
	endfunction

	in_item_t             item_s1;
	logic                 valid_s1;
	logic                 advance;

	pattern_t             cur_q, saved_q;
	logic [23:0]          color_q;
	logic [TIMER_W-1:0]   since_toggle_q, since_start_q;
	logic [2:0]           flash_q;

	pattern_t             cur_d, saved_d;
	logic [23:0]          color_d;
	logic [TIMER_W-1:0]   st_d, ss_d;
	logic [2:0]           flash_d;
	logic                 sel_req;
	logic [2:0]           sel_pat;

	assign advance  = valid_s1 && res_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	always_comb begin
		cur_d   = cur_q;
		saved_d = saved_q;
		color_d = color_q;
		st_d    = since_toggle_q;
		ss_d    = since_start_q;
		flash_d = flash_q;
		sel_req = 1'b0;
		sel_pat = item_s1.pattern;

		if (item_s1.mode) begin
			sel_req = 1'b1;
		end else begin
			st_d = sat_inc(since_toggle_q);
			ss_d = sat_inc(since_start_q);
			case (cur_q)
				PAT_SLOW: begin
					if (st_d >= cfg.slow_half_period) begin
						color_d = (color_q != COLOR_BLACK) ? COLOR_BLACK : COLOR_DIM_BLUE;
						st_d    = '0;
					end
				end
				PAT_FAST: begin
					if (st_d >= cfg.fast_half_period) begin
						color_d = (color_q != COLOR_BLACK) ? COLOR_BLACK : COLOR_DIM_BLUE;
						st_d    = '0;
					end
				end
				PAT_DOUBLE: begin
					if (flash_q < DOUBLE_TOGGLES) begin
						if (st_d >= cfg.flash_half_period) begin
							color_d = (color_q != COLOR_BLACK) ? COLOR_BLACK : COLOR_CYAN;
							st_d    = '0;
							flash_d = flash_q + 3'd1;
						end
					end else if (st_d >= cfg.double_gap) begin
						// burst done: restart it after the gap
						flash_d = '0;
						st_d    = '0;
					end
				end
				PAT_SUCCESS: begin
					if (flash_q < SUCCESS_TOGGLES) begin
						if (st_d >= cfg.flash_half_period) begin
							color_d = (color_q != COLOR_BLACK) ? COLOR_BLACK : COLOR_GREEN;
							st_d    = '0;
							flash_d = flash_q + 3'd1;
						end
					end else if (ss_d >= cfg.success_hold) begin
						sel_req = 1'b1;
						sel_pat = PAT_SOLID;
					end
				end
				PAT_ERROR: begin
					if (ss_d < cfg.error_on_time) begin
						// red only goes on over a dark LED
						if (color_q == COLOR_BLACK) begin
							color_d = COLOR_RED;
						end
					end else if (ss_d < cfg.error_total_time) begin
						color_d = COLOR_BLACK;
					end else begin
						sel_req = 1'b1;
						sel_pat = saved_q;
					end
				end
				default: ;
			endcase
		end

		// pattern change: drop unknown codes and reselection of the active one
		if (sel_req && (sel_pat <= PAT_ERROR) && (sel_pat != cur_q)) begin
			if ((sel_pat == PAT_SUCCESS) || (sel_pat == PAT_ERROR)) begin
				saved_d = cur_q;
			end
			cur_d   = pattern_t'(sel_pat);
			flash_d = '0;
			ss_d    = '0;
			st_d    = '0;
			if (sel_pat == PAT_OFF) begin
				color_d = COLOR_BLACK;
			end else if (sel_pat == PAT_SOLID) begin
				color_d = COLOR_DIM_GREEN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q          <= PAT_OFF;
			saved_q        <= PAT_OFF;
			color_q        <= COLOR_BLACK;
			since_toggle_q <= '0;
			since_start_q  <= '0;
			flash_q        <= '0;
		end else if (advance) begin
			cur_q          <= cur_d;
			saved_q        <= saved_d;
			color_q        <= color_d;
			since_toggle_q <= st_d;
			since_start_q  <= ss_d;
			flash_q        <= flash_d;
		end
	end

	assign res_valid               = valid_s1;
	assign res_data.red            = color_d[23:16];
	assign res_data.green          = color_d[15:8];
	assign res_data.blue           = color_d[7:0];
	assign res_data.active_pattern = cur_d;
	assign res_data.lit            = |color_d;

endmodule

`default_nettype wire

// ----- rtl/rgbsps_out.sv -----
// Output register for result transactions; frees the core whenever the
// register is empty or being drained. Depends on rgbsps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rgbsps_out (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   res_valid,
	output logic                  res_ready,
	input  wire rgbsps_pkg::out_item_t res_data,
	output logic                  out_valid,
	input  wire                   out_ready,
	output rgbsps_pkg::out_item_t out_data
);
	import rgbsps_pkg::*;

	logic      out_valid_q;
	out_item_t out_data_q;

	assign res_ready = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_data_q <= res_data;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/rgb_status_pattern_sequencer_unit.sv -----
// RGB status pattern sequencer top level: config bank, core and output register.
// Path: a transaction is held in the core's input register, then in the output register, and is presented on out_data.
// Throughput: one transaction per cycle unless out_ready is held low; the core updates its state once per transaction.
// Reset (arst_n low): pattern off, colour black, counters cleared, timings at defaults.
// Depends on rgbsps_pkg, rgbsps_cfg, rgbsps_core and rgbsps_out.
`timescale 1ns / 1ps
`default_nettype none

module rgb_status_pattern_sequencer_unit (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           in_valid,
	output logic                          in_ready,
	input  wire rgbsps_pkg::in_item_t     in_data,
	output logic                          out_valid,
	input  wire                           out_ready,
	output rgbsps_pkg::out_item_t         out_data,
	input  wire                           cfg_we,
	input  wire  [rgbsps_pkg::IDX_W-1:0]  cfg_index,
	input  wire  [rgbsps_pkg::CFG_W-1:0]  cfg_wdata
);
	import rgbsps_pkg::*;

	cfg_t      cfg;
	logic      res_valid;
	logic      res_ready;
	out_item_t res_data;

	rgbsps_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	rgbsps_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

	rgbsps_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

// ----- tb/tb_rgb_status_pattern_sequencer_unit.sv -----
`timescale 1ns / 1ps
// Self-checking bench for rgb_status_pattern_sequencer_unit: ticks and pattern selects in,
// LED drive levels out, each result predicted in a scoreboard class and compared per field.
// Depends on rgbsps_pkg and the sequencer RTL.

module tb_rgb_status_pattern_sequencer_unit;
	import rgbsps_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_PAD      = 4;
	localparam int HOLD_CYCLES    = 300;
	localparam int MAX_REPORTS    = 10;

	localparam logic       MODE_TICK   = 1'b0;
	localparam logic       MODE_SELECT = 1'b1;
	localparam logic [2:0] PAT_UNUSED  = 3'd7;

	class led_scoreboard;
		logic [CFG_W-1:0]   period_ms [7];
		pattern_t           cur_pat;
		pattern_t           saved_pat;
		logic [23:0]        colour;
		logic [TIMER_W-1:0] since_toggle;
		logic [TIMER_W-1:0] since_start;
		logic [2:0]         flashes;
		out_item_t          expected_leds [$];
		int                 failures;

		function new();
			period_ms[REG_SLOW_HALF]    = RST_SLOW_HALF;
			period_ms[REG_FAST_HALF]    = RST_FAST_HALF;
			period_ms[REG_FLASH_HALF]   = RST_FLASH_HALF;
			period_ms[REG_DOUBLE_GAP]   = RST_DOUBLE_GAP;
			period_ms[REG_SUCCESS_HOLD] = RST_SUCCESS_HOLD;
			period_ms[REG_ERROR_ON]     = RST_ERROR_ON;
			period_ms[REG_ERROR_TOTAL]  = RST_ERROR_TOTAL;
			cur_pat      = PAT_OFF;
			saved_pat    = PAT_OFF;
			colour       = COLOR_BLACK;
			since_toggle = '0;
			since_start  = '0;
			flashes      = '0;
			failures     = 0;
		endfunction

		function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			period_ms[idx] = val;
		endfunction

		function void enter_pattern(logic [2:0] p);
			if (p > PAT_ERROR || p == cur_pat)
				return;
			if (p == PAT_SUCCESS || p == PAT_ERROR)
				saved_pat = cur_pat;
			cur_pat      = pattern_t'(p);
			flashes      = '0;
			since_start  = '0;
			since_toggle = '0;
			if (p == PAT_OFF)
				colour = COLOR_BLACK;
			else if (p == PAT_SOLID)
				colour = COLOR_DIM_GREEN;
		endfunction

		function void flip(logic [23:0] c);
			colour       = (colour != COLOR_BLACK) ? COLOR_BLACK : c;
			since_toggle = '0;
		endfunction

		function void advance_ms();
			if (since_toggle != TIMER_MAX)
				since_toggle = since_toggle + 1'b1;
			if (since_start != TIMER_MAX)
				since_start = since_start + 1'b1;
			case (cur_pat)
				PAT_SLOW: if (since_toggle >= period_ms[REG_SLOW_HALF])
					flip(COLOR_DIM_BLUE);
				PAT_FAST: if (since_toggle >= period_ms[REG_FAST_HALF])
					flip(COLOR_DIM_BLUE);
				PAT_DOUBLE: begin
					if (flashes < DOUBLE_TOGGLES) begin
						if (since_toggle >= period_ms[REG_FLASH_HALF]) begin
							flip(COLOR_CYAN);
							flashes = flashes + 1'b1;
						end
					end else if (since_toggle >= period_ms[REG_DOUBLE_GAP]) begin
						flashes      = '0;
						since_toggle = '0;
					end
				end
				PAT_SUCCESS: begin
					if (flashes < SUCCESS_TOGGLES) begin
						if (since_toggle >= period_ms[REG_FLASH_HALF]) begin
							flip(COLOR_GREEN);
							flashes = flashes + 1'b1;
						end
					end else if (since_start >= period_ms[REG_SUCCESS_HOLD]) begin
						enter_pattern(PAT_SOLID);
					end
				end
				PAT_ERROR: begin
					// red only lands on a dark LED; any other lit colour waits for the off phase
					if (since_start < period_ms[REG_ERROR_ON]) begin
						if (colour == COLOR_BLACK)
							colour = COLOR_RED;
					end else if (since_start < period_ms[REG_ERROR_TOTAL]) begin
						colour = COLOR_BLACK;
					end else begin
						enter_pattern(saved_pat);
					end
				end
				default: ;
			endcase
		endfunction

		function void note_input(in_item_t it);
			out_item_t want;
			if (it.mode == MODE_SELECT)
				enter_pattern(it.pattern);
			else
				advance_ms();
			want.red            = colour[23:16];
			want.green          = colour[15:8];
			want.blue           = colour[7:0];
			want.active_pattern = cur_pat;
			want.lit            = (colour != COLOR_BLACK);
			expected_leds.push_back(want);
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (expected_leds.size() == 0) begin
				failures++;
				if (failures <= MAX_REPORTS)
					$display("%0t: unexpected LED transaction r=%0d g=%0d b=%0d pat=%0d lit=%0d",
						$time, got.red, got.green, got.blue, got.active_pattern, got.lit);
				return;
			end
			want = expected_leds.pop_front();
			if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue
				|| got.active_pattern !== want.active_pattern || got.lit !== want.lit) begin
				failures++;
				if (failures <= MAX_REPORTS) begin
					$display("%0t: LED mismatch: expected r=%0d g=%0d b=%0d pat=%0d lit=%0d",
						$time, want.red, want.green, want.blue, want.active_pattern, want.lit);
					$display("    got r=%0d g=%0d b=%0d pat=%0d lit=%0d",
						got.red, got.green, got.blue, got.active_pattern, got.lit);
				end
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	in_item_t         in_data;
	logic             out_valid;
	logic             out_ready;
	out_item_t        out_data;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_wdata;

	int send_idle_pct;
	int recv_idle_pct;
	led_scoreboard sb;

	rgb_status_pattern_sequencer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic send_item(input in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_input(it);
	endtask

	task automatic send_ticks(input int n);
		in_item_t it;
		repeat (n) begin
			it.mode    = MODE_TICK;
			it.pattern = 3'($urandom_range(7));
			send_item(it);
		end
	endtask

	task automatic send_select(input logic [2:0] p);
		in_item_t it;
		it.mode    = MODE_SELECT;
		it.pattern = p;
		send_item(it);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.expected_leds.size() != 0)
			@(posedge clk);
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic apply_settings(input cfg_t c);
		wait_drained();
		write_reg(REG_SLOW_HALF, c.slow_half_period);
		write_reg(REG_FAST_HALF, c.fast_half_period);
		write_reg(REG_FLASH_HALF, c.flash_half_period);
		write_reg(REG_DOUBLE_GAP, c.double_gap);
		write_reg(REG_SUCCESS_HOLD, c.success_hold);
		write_reg(REG_ERROR_ON, c.error_on_time);
		write_reg(REG_ERROR_TOTAL, c.error_total_time);
		cfg_we <= 1'b0;
	endtask

	function automatic cfg_t random_settings(input int lo, input int hi);
		cfg_t c;
		c.slow_half_period  = CFG_W'($urandom_range(hi, lo));
		c.fast_half_period  = CFG_W'($urandom_range(hi, lo));
		c.flash_half_period = CFG_W'($urandom_range(hi, lo));
		c.double_gap        = CFG_W'($urandom_range(hi, lo));
		c.success_hold      = CFG_W'($urandom_range(hi, lo));
		c.error_on_time     = CFG_W'($urandom_range(hi, lo));
		c.error_total_time  = CFG_W'($urandom_range(hi, lo));
		return c;
	endfunction

	// mostly a select followed by a run of up to 60 ticks, which may finish flashes and restores
	task automatic run_bursts(input int n);
		int counted;
		int roll;
		int run_len;
		counted = 0;
		while (counted < n) begin
			roll = $urandom_range(99);
			if (roll < 75) begin
				send_select(3'($urandom_range(6)));
				run_len = $urandom_range(60);
				send_ticks(run_len);
				counted += 1 + run_len;
			end else if (roll < 85) begin
				send_select(3'($urandom_range(6)));
				counted++;
			end else if (roll < 93) begin
				send_select(PAT_UNUSED);
				counted++;
			end else begin
				send_select(sb.cur_pat);
				counted++;
			end
		end
	endtask

	initial begin : result_sink
		int taken;
		int hold_left;
		taken     = 0;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				sb.check_result(out_data);
				taken++;
				// hold off long enough for the block to back up into its input
				if (taken % 1500 == 700)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
				$display("** rgb_status_pattern_sequencer_unit: FAILED **");
				$finish;
			end
		end
	end

	initial begin : stimulus
		cfg_t c;
		sb        = new();
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		send_idle_pct = 20;
		recv_idle_pct = 65;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset timings: fast blink toggles, then the first double blink flashes
		send_select(PAT_FAST);
		send_ticks(155);
		send_select(PAT_DOUBLE);
		send_ticks(205);

		c.slow_half_period  = 16'd3;
		c.fast_half_period  = 16'd2;
		c.flash_half_period = 16'd1;
		c.double_gap        = 16'd2;
		c.success_hold      = 16'd10;
		c.error_on_time     = 16'd3;
		c.error_total_time  = 16'd6;
		apply_settings(c);

		send_ticks(1);
		send_select(PAT_OFF);
		send_select(PAT_OFF);
		send_select(PAT_UNUSED);
		send_select(PAT_SOLID);
		send_select(PAT_SOLID);
		// green stays lit through the error on time, then restore solid
		send_select(PAT_ERROR);
		send_ticks(7);
		send_select(PAT_SLOW);
		send_ticks(3);
		send_select(PAT_FAST);
		send_ticks(2);
		send_select(PAT_DOUBLE);
		send_select(PAT_SUCCESS);
		send_select(PAT_ERROR);
		send_select(PAT_UNUSED);
		send_select(PAT_OFF);

		apply_settings(random_settings(1, 8));
		run_bursts(80);

		send_idle_pct = 65;
		recv_idle_pct = 20;
		apply_settings(random_settings(1, 1));
		run_bursts(80);
		apply_settings(random_settings(0, 0));
		run_bursts(80);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		c = '1;
		apply_settings(c);
		run_bursts(40);
		c = random_settings(1, 6);
		c.slow_half_period = '1;
		c.double_gap       = '1;
		c.success_hold     = '1;
		c.error_total_time = '1;
		apply_settings(c);
		run_bursts(80);
		apply_settings(random_settings(1, 20));
		run_bursts(80);

		wait_drained();
		if (sb.failures == 0 && sb.expected_leds.size() == 0)
			$display("** rgb_status_pattern_sequencer_unit: PASSED **");
		else
			$display("** rgb_status_pattern_sequencer_unit: FAILED **");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/rgbsps_pkg.sv
rtl/rgbsps_cfg.sv
rtl/rgbsps_core.sv
rtl/rgbsps_out.sv
rtl/rgb_status_pattern_sequencer_unit.sv
tb/tb_rgb_status_pattern_sequencer_unit.sv
